// ----- rtl/core/cbq_pkg.sv -----
// Shared types, coefficient ROM and fixed-point helpers for the cascaded
// biquad low-pass filter. No dependencies.
package cbq_pkg;

  localparam int unsigned CBQ_SECTIONS = 5;
  localparam int unsigned ROM_SECTIONS = 5;

  // rate_select codes
  localparam logic [1:0] RATE_32K  = 2'd0;
  localparam logic [1:0] RATE_44K1 = 2'd1;
  localparam logic [1:0] RATE_48K  = 2'd2;
  localparam logic [1:0] RATE_RSVD = 2'd3;

  typedef logic signed [63:0] sig_t;
  typedef logic signed [32:0] coef_t;

  typedef enum logic [1:0] {
    PH_MUL_LO,
    PH_MUL_HI,
    PH_ROUND,
    PH_ACC
  } ph_e;

  typedef struct packed {
    logic valid;
    logic clip;
    sig_t data;
  } cbq_link_t;

  typedef struct packed {
    sig_t value;
    logic clip;
  } sat_res_t;

  localparam longint P5_16   = 64'sd152587890625;
  localparam longint P5_16X2 = 2 * P5_16;

  // round(n * 1e-16 * 2^30), ties away from zero; elaboration only
  function automatic longint q30(longint n);
    return (n / P5_16) * 64'sd16384 + ((n % P5_16) * 64'sd32768 + P5_16) / P5_16X2;
  endfunction

  localparam coef_t CB1_0 = coef_t'(q30(64'sd10348719804883380));
  localparam coef_t CB2_1 = coef_t'(q30(64'sd10536273508975760));
  localparam coef_t CB1_1 = coef_t'(q30(64'sd20524248075015460));
  localparam coef_t CB2_2 = coef_t'(q30(64'sd10114023368782820));
  localparam coef_t CB1_2 = coef_t'(q30(64'sd20102338577982410));
  localparam coef_t CB2_3 = coef_t'(q30(64'sd9662620695152961));
  localparam coef_t CB1_3 = coef_t'(q30(64'sd19651321404176480));
  localparam coef_t CB2_4 = coef_t'(q30(64'sd9384420320790645));
  localparam coef_t CB1_4 = coef_t'(q30(64'sd19373372137942340));

  // [set][section][a2, a1, b2, b1]
  localparam coef_t COEF_ROM [3][ROM_SECTIONS][4] = '{
    '{
      '{coef_t'(0), coef_t'(q30(64'sd9062755965210486)), coef_t'(0), CB1_0},
      '{coef_t'(-q30(64'sd8313685839740158)), coef_t'(q30(64'sd18225508469432870)),
        CB2_1, CB1_1},
      '{coef_t'(-q30(64'sd8603595383531635)), coef_t'(q30(64'sd18514080256599170)),
        CB2_2, CB1_2},
      '{coef_t'(-q30(64'sd9065403310196870)), coef_t'(q30(64'sd18973593583168670)),
        CB2_3, CB1_3},
      '{coef_t'(-q30(64'sd9665289468865543)), coef_t'(q30(64'sd19570591824400840)),
        CB2_4, CB1_4}
    },
    '{
      '{coef_t'(0), coef_t'(q30(64'sd9301128211196789)), coef_t'(0), CB1_0},
      '{coef_t'(-q30(64'sd8751312607060559)), coef_t'(q30(64'sd18703667007270620)),
        CB2_1, CB1_1},
      '{coef_t'(-q30(64'sd8974480527082694)), coef_t'(q30(64'sd18927183043607340)),
        CB2_2, CB1_2},
      '{coef_t'(-q30(64'sd9309107246832005)), coef_t'(q30(64'sd19260127300018110)),
        CB2_3, CB1_3},
      '{coef_t'(-q30(64'sd9755699206694750)), coef_t'(q30(64'sd19705538220590740)),
        CB2_4, CB1_4}
    },
    '{
      '{coef_t'(0), coef_t'(q30(64'sd9338952139211192)), coef_t'(0), CB1_0},
      '{coef_t'(-q30(64'sd8851313402201296)), coef_t'(q30(64'sd18810329661504470)),
        CB2_1, CB1_1},
      '{coef_t'(-q30(64'sd9073018742276428)), coef_t'(q30(64'sd19034484125754580)),
        CB2_2, CB1_2},
      '{coef_t'(-q30(64'sd9356046394317145)), coef_t'(q30(64'sd19314553425049130)),
        CB2_3, CB1_3},
      '{coef_t'(-q30(64'sd9775108620840036)), coef_t'(q30(64'sd19732630486666020)),
        CB2_4, CB1_4}
    }
  };

  // gain mantissas, scale 2^-54
  localparam logic [14:0] GAIN_ROM [3] = '{15'd22630, 15'd1359, 15'd645};

  // unused code falls back to the 48 kHz set
  function automatic logic [1:0] set_idx(logic [1:0] rate);
    return (rate == RATE_32K || rate == RATE_44K1) ? rate : RATE_48K;
  endfunction

  function automatic logic [63:0] mag64(sig_t v);
    return v[63] ? 64'(64'd0 - $unsigned(v)) : $unsigned(v);
  endfunction

  // combine the two 32-bit partial products, round at 2^sh, saturate to 64 bits
  function automatic sat_res_t rnd_sat(logic [63:0] plo, logic [63:0] phi, logic neg,
                                       int unsigned sh);
    logic [96:0] p;
    logic [96:0] r;
    logic [96:0] m;
    logic        over;
    logic [63:0] mag;
    sat_res_t    res;
    p    = {33'd0, plo} + {1'b0, phi, 32'd0};
    r    = p + (97'd1 << (sh - 1));
    m    = r >> sh;
    over = |m[96:64];
    mag  = m[63:0];
    if (neg) begin
      if (over || mag > 64'h8000_0000_0000_0000) begin
        res = '{value: {1'b1, 63'd0}, clip: 1'b1};
      end else begin
        res = '{value: sig_t'(64'd0 - mag), clip: 1'b0};
      end
    end else begin
      if (over || mag[63]) begin
        res = '{value: {1'b0, {63{1'b1}}}, clip: 1'b1};
      end else begin
        res = '{value: sig_t'(mag), clip: 1'b0};
      end
    end
    return res;
  endfunction

  function automatic sat_res_t sat_add(sig_t a, sig_t b);
    logic signed [64:0] s;
    sat_res_t           res;
    s = {a[63], a} + {b[63], b};
    if (s[64] != s[63]) begin
      res = '{value: s[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}, clip: 1'b1};
    end else begin
      res = '{value: s[63:0], clip: 1'b0};
    end
    return res;
  endfunction

endpackage

// ----- rtl/core/cbq_cell.sv -----
// One second-order section of the cascade: holds its x/y history and works
// through four product terms with a shared 32x32 multiplier. Uses cbq_pkg.
module cbq_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [1:0]        rate_select_i,
  input  cbq_pkg::cbq_link_t link_i,
  output cbq_pkg::cbq_link_t link_o
);
  import cbq_pkg::*;

  ph_e         ph_q, ph_d;
  logic [1:0]  k_q;
  logic        busy_q;
  sig_t        x1_q, x2_q, y1_q, y2_q;
  sig_t        xcur_q, acc_q, term_q;
  logic        clip_q;
  logic [63:0] plo_q, phi_q;
  cbq_link_t   out_q;

  sig_t        s;
  coef_t       c;
  logic [63:0] u;
  logic [31:0] cm;
  logic        neg;
  sat_res_t    rs, sa;

  always_comb begin
    case (k_q)
      2'd0:    s = x1_q;
      2'd1:    s = x2_q;
      2'd2:    s = y1_q;
      default: s = y2_q;
    endcase
  end

  // ROM order is a2, a1, b2, b1; terms run b1, b2, a1, a2
  if (IDX < ROM_SECTIONS) begin : g_rom
    assign c = COEF_ROM[set_idx(rate_select_i)][IDX][2'd3 - k_q];
  end else begin : g_pass
    assign c = '0;
  end

  assign u   = mag64(s);
  assign cm  = c[32] ? 32'(33'd0 - $unsigned(c)) : 32'($unsigned(c));
  assign neg = s[63] ^ c[32];
  assign rs  = rnd_sat(plo_q, phi_q, neg, 30);
  assign sa  = sat_add(acc_q, term_q);

  always_comb begin
    case (ph_q)
      PH_MUL_LO: ph_d = busy_q ? PH_MUL_HI : PH_MUL_LO;
      PH_MUL_HI: ph_d = PH_ROUND;
      PH_ROUND:  ph_d = PH_ACC;
      PH_ACC:    ph_d = PH_MUL_LO;
      default:   ph_d = PH_MUL_LO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q   <= PH_MUL_LO;
      k_q    <= 2'd0;
      busy_q <= 1'b0;
      x1_q   <= '0;
      x2_q   <= '0;
      y1_q   <= '0;
      y2_q   <= '0;
      out_q  <= '0;
    end else begin
      ph_q        <= ph_d;
      out_q.valid <= 1'b0;
      if (!busy_q) begin
        if (link_i.valid) begin
          busy_q <= 1'b1;
          k_q    <= 2'd0;
        end
      end else if (ph_q == PH_ACC) begin
        k_q <= k_q + 2'd1;
        if (k_q == 2'd3) begin
          busy_q      <= 1'b0;
          x2_q        <= x1_q;
          x1_q        <= xcur_q;
          y2_q        <= y1_q;
          y1_q        <= sa.value;
          out_q.valid <= 1'b1;
          out_q.data  <= sa.value;
          out_q.clip  <= clip_q | sa.clip;
        end
      end
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (link_i.valid) begin
        xcur_q <= link_i.data;
        acc_q  <= link_i.data;
        clip_q <= link_i.clip;
      end
    end else begin
      case (ph_q)
        PH_MUL_LO: plo_q <= 64'(u[31:0]) * 64'(cm);
        PH_MUL_HI: phi_q <= 64'(u[63:32]) * 64'(cm);
        PH_ROUND: begin
          term_q <= rs.value;
          clip_q <= clip_q | rs.clip;
        end
        PH_ACC: begin
          acc_q  <= sa.value;
          clip_q <= clip_q | sa.clip;
        end
        default: ;
      endcase
    end
  end

  assign link_o = out_q;

endmodule

// ----- rtl/core/cbq_gain.sv -----
// Output gain stage: multiplies the last section's output by the gain
// mantissa, rounds at 2^56 and clamps to 16 bits. Uses cbq_pkg.
module cbq_gain (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic [1:0]         rate_select_i,
  input  cbq_pkg::cbq_link_t link_i,
  output logic               valid_o,
  output logic signed [15:0] sample_o,
  output logic               clip_o
);
  import cbq_pkg::*;

  ph_e                ph_q, ph_d;
  logic               busy_q;
  logic               valid_q;
  sig_t               x_q;
  logic               clip_q;
  logic [63:0]        plo_q, phi_q;
  sat_res_t           g_q;
  logic signed [15:0] sample_q;
  logic               oclip_q;

  logic [63:0] u;
  logic [31:0] cm;
  sat_res_t    rs;
  logic        hi, lo;

  assign u  = mag64(x_q);
  assign cm = 32'(GAIN_ROM[set_idx(rate_select_i)]);
  assign rs = rnd_sat(plo_q, phi_q, x_q[63], 56);
  assign hi = g_q.value > 64'sd32767;
  assign lo = g_q.value < -64'sd32768;

  always_comb begin
    case (ph_q)
      PH_MUL_LO: ph_d = busy_q ? PH_MUL_HI : PH_MUL_LO;
      PH_MUL_HI: ph_d = PH_ROUND;
      PH_ROUND:  ph_d = PH_ACC;
      PH_ACC:    ph_d = PH_MUL_LO;
      default:   ph_d = PH_MUL_LO;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q    <= PH_MUL_LO;
      busy_q  <= 1'b0;
      valid_q <= 1'b0;
    end else begin
      ph_q    <= ph_d;
      valid_q <= 1'b0;
      if (!busy_q) begin
        busy_q <= link_i.valid;
      end else if (ph_q == PH_ACC) begin
        busy_q  <= 1'b0;
        valid_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!busy_q) begin
      if (link_i.valid) begin
        x_q    <= link_i.data;
        clip_q <= link_i.clip;
      end
    end else begin
      case (ph_q)
        PH_MUL_LO: plo_q <= 64'(u[31:0]) * 64'(cm);
        PH_MUL_HI: phi_q <= 64'(u[63:32]) * 64'(cm);
        PH_ROUND:  g_q   <= rs;
        PH_ACC: begin
          sample_q <= hi ? 16'sh7fff : (lo ? 16'sh8000 : g_q.value[15:0]);
          oclip_q  <= clip_q | g_q.clip | hi | lo;
        end
        default: ;
      endcase
    end
  end

  assign valid_o  = valid_q;
  assign sample_o = sample_q;
  assign clip_o   = oclip_q;

endmodule

// ----- rtl/core/cascaded_biquad_lowpass.sv -----
// Cascaded biquad low-pass: a row of section cells, then the gain stage.
// Each cell picks up the item, then runs four split multiplies (low and high
// halves), each followed by round and accumulate. Throughput: one item at a
// time; the input reopens in the same cycle that the result lands in the
// output register, which waits while out_stall_i holds a shown result.
// Reset clears all section history and sets rate_select to 48 kHz.
module cascaded_biquad_lowpass #(
  parameter int unsigned SECTIONS = cbq_pkg::CBQ_SECTIONS
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [15:0] sample_in_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [15:0] sample_out_o,
  output logic               clipped_o
);
  import cbq_pkg::*;

  logic [1:0]         rate_q;
  logic               busy_q;
  logic               pend_q;
  logic signed [15:0] pend_sample_q;
  logic               pend_clip_q;
  logic               out_valid_q;
  logic signed [15:0] sample_q;
  logic               clip_q;

  logic               accept;
  logic               load;
  cbq_link_t          link [SECTIONS + 1];
  logic               g_valid;
  logic signed [15:0] g_sample;
  logic               g_clip;

  assign accept = in_valid_i && !busy_q;
  assign load   = pend_q && (!out_valid_q || !out_stall_i);

  assign link[0].valid = accept;
  assign link[0].clip  = 1'b0;
  assign link[0].data  = {{46{sample_in_i[15]}}, sample_in_i, 2'b00};

  for (genvar i = 0; i < SECTIONS; i++) begin : g_cell
    cbq_cell #(
      .IDX(i)
    ) u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .rate_select_i(rate_q),
      .link_i       (link[i]),
      .link_o       (link[i + 1])
    );
  end

  cbq_gain u_gain (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .rate_select_i(rate_q),
    .link_i       (link[SECTIONS]),
    .valid_o      (g_valid),
    .sample_o     (g_sample),
    .clip_o       (g_clip)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rate_q      <= RATE_48K;
      busy_q      <= 1'b0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        rate_q <= cfg_wdata_i;
      end
      if (accept) begin
        busy_q <= 1'b1;
      end else if (load) begin
        busy_q <= 1'b0;
      end
      if (g_valid) begin
        pend_q <= 1'b1;
      end else if (load) begin
        pend_q <= 1'b0;
      end
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (g_valid) begin
      pend_sample_q <= g_sample;
      pend_clip_q   <= g_clip;
    end
    if (load) begin
      sample_q <= pend_sample_q;
      clip_q   <= pend_clip_q;
    end
  end

  assign in_stall_o   = busy_q;
  assign out_valid_o  = out_valid_q;
  assign sample_out_o = sample_q;
  assign clipped_o    = clip_q;

endmodule

// ----- rtl/core/cbq_checker.sv -----
// Port-level checks for cascaded_biquad_lowpass, bound to the top level.
// Depends only on the top level's ports.
module cbq_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               in_valid_i,
  input logic               in_stall_o,
  input logic               out_valid_o,
  input logic               out_stall_i,
  input logic signed [15:0] sample_out_o,
  input logic               clipped_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(sample_out_o) && $stable(clipped_o))
    else $error("stalled output item changed");

  // one item in flight: accepting an item closes the input
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input not stalled after accepting an item");

  // input reopens exactly when a result lands in the output register
  a_reopen_on_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $fell(in_stall_o))
    else $error("result shown without releasing the input");

  // stall rises only because an item came in
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stalled with no item accepted");

endmodule

bind cascaded_biquad_lowpass cbq_checker u_cbq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .sample_out_o(sample_out_o),
  .clipped_o   (clipped_o)
);
